[rtl/core/mdls_pkg.sv]
package mdls_pkg;

  // Parse phases, one-hot
  typedef enum logic [11:0] {
    PH_INDENT      = 12'b0000_0000_0001,
    PH_HASH        = 12'b0000_0000_0010,
    PH_MARKER      = 12'b0000_0000_0100,
    PH_QUOTE_SPACE = 12'b0000_0000_1000,
    PH_LIST_SKIP   = 12'b0000_0001_0000,
    PH_TOP         = 12'b0000_0010_0000,
    PH_STAR        = 12'b0000_0100_0000,
    PH_BOLD        = 12'b0000_1000_0000,
    PH_BOLD_STAR   = 12'b0001_0000_0000,
    PH_SPAN        = 12'b0010_0000_0000,
    PH_LINK_AFTER  = 12'b0100_0000_0000,
    PH_URL         = 12'b1000_0000_0000
  } phase_e;

  localparam logic [2:0] LT_NORMAL   = 3'd0;
  localparam logic [2:0] LT_HEAD1    = 3'd1;
  localparam logic [2:0] LT_HEAD2    = 3'd2;
  localparam logic [2:0] LT_HEAD3    = 3'd3;
  localparam logic [2:0] LT_LIST     = 3'd4;
  localparam logic [2:0] LT_QUOTE    = 3'd5;
  localparam logic [2:0] LT_CODE     = 3'd6;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_HASH     = 8'h23;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [7:0] CH_GT       = 8'h3E;
  localparam logic [7:0] CH_LBRACK   = 8'h5B;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_RBRACK   = 8'h5D;
  localparam logic [7:0] CH_UNDER    = 8'h5F;
  localparam logic [7:0] CH_TICK     = 8'h60;

  localparam logic [7:0] OUT_CAP     = 8'd255;
  localparam logic [9:0] INDENT_MAX  = 10'd510;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned CNT_W      = 3;

  typedef struct packed {
    logic [7:0] text_char;
    logic [2:0] line_type;
    logic [8:0] indent;
    logic [7:0] char_count;
    logic       line_done;
  } res_t;

  typedef struct packed {
    phase_e     phase;
    logic       pend_star;   // held marker byte is '*' (else '-')
    logic       prev_bs;     // previous raw byte was a backslash
    logic [7:0] span_delim;
    logic [2:0] hash_total;
    logic [7:0] kept;
    logic [8:0] indent;
    logic [2:0] line_type;
  } line_t;

  typedef struct packed {
    line_t      st;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } work_t;

  localparam line_t LINE_RESET = '{
    phase:      PH_INDENT,
    pend_star:  1'b0,
    prev_bs:    1'b0,
    span_delim: 8'd0,
    hash_total: 3'd0,
    kept:       8'd0,
    indent:     9'd0,
    line_type:  LT_NORMAL
  };

endpackage

[rtl/core/mdls_parse.sv]
module mdls_parse (
  input  mdls_pkg::line_t line_i,
  input  logic [7:0]      ch_i,
  input  logic            close_i,
  output mdls_pkg::work_t work_o
);

  function automatic mdls_pkg::work_t append(mdls_pkg::work_t w, mdls_pkg::res_t r);
    if (w.n == 2'd0) begin
      w.r0 = r;
    end else if (w.n == 2'd1) begin
      w.r1 = r;
    end
    if (w.n != 2'd2) begin
      w.n = w.n + 2'd1;
    end
    return w;
  endfunction

  function automatic mdls_pkg::work_t put_char(mdls_pkg::work_t w, logic [7:0] c);
    mdls_pkg::res_t r;
    if (w.st.kept < mdls_pkg::OUT_CAP) begin
      w.st.kept    = w.st.kept + 8'd1;
      r.text_char  = c;
      r.line_type  = w.st.line_type;
      r.indent     = w.st.indent;
      r.char_count = w.st.kept;
      r.line_done  = 1'b0;
      w = append(w, r);
    end
    return w;
  endfunction

  function automatic logic [2:0] heading_type(logic [2:0] h);
    logic [2:0] t;
    case (h) inside
      3'd1:         t = mdls_pkg::LT_HEAD1;
      3'd2:         t = mdls_pkg::LT_HEAD2;
      [3'd3:3'd6]:  t = mdls_pkg::LT_HEAD3;
      default:      t = mdls_pkg::LT_NORMAL;
    endcase
    return t;
  endfunction

  function automatic logic italic_ok(mdls_pkg::line_t s);
    return (s.kept != 8'd0) && !s.prev_bs;
  endfunction

  // Body phases that need no replay of an earlier byte
  function automatic mdls_pkg::work_t body_simple(mdls_pkg::work_t w, logic [7:0] c);
    case (w.st.phase)
      mdls_pkg::PH_BOLD: begin
        if (c == mdls_pkg::CH_STAR) begin
          w.st.pend_star = 1'b1;
          w.st.phase     = mdls_pkg::PH_BOLD_STAR;
          return w;
        end
        w = put_char(w, c);
      end
      mdls_pkg::PH_SPAN: begin
        if (c == w.st.span_delim) begin
          w.st.phase = (w.st.span_delim == mdls_pkg::CH_RBRACK) ?
                       mdls_pkg::PH_LINK_AFTER : mdls_pkg::PH_TOP;
        end else begin
          w = put_char(w, c);
        end
      end
      mdls_pkg::PH_URL: begin
        if (c == mdls_pkg::CH_RPAREN) begin
          w.st.phase = mdls_pkg::PH_TOP;
        end
      end
      default: begin
        w.st.phase = mdls_pkg::PH_TOP;
        if (c == mdls_pkg::CH_STAR) begin
          w.st.pend_star = 1'b1;
          w.st.phase     = mdls_pkg::PH_STAR;
          return w;
        end
        if (c == mdls_pkg::CH_UNDER && italic_ok(w.st)) begin
          w.st.phase      = mdls_pkg::PH_SPAN;
          w.st.span_delim = mdls_pkg::CH_UNDER;
        end else if (c == mdls_pkg::CH_TICK) begin
          w.st.phase      = mdls_pkg::PH_SPAN;
          w.st.span_delim = mdls_pkg::CH_TICK;
        end else if (c == mdls_pkg::CH_LBRACK) begin
          w.st.phase      = mdls_pkg::PH_SPAN;
          w.st.span_delim = mdls_pkg::CH_RBRACK;
        end else begin
          w = put_char(w, c);
        end
      end
    endcase
    w.st.prev_bs = (c == mdls_pkg::CH_BSLASH);
    return w;
  endfunction

  function automatic mdls_pkg::work_t body_byte(mdls_pkg::work_t w, logic [7:0] c);
    case (w.st.phase)
      mdls_pkg::PH_STAR: begin
        if (c == mdls_pkg::CH_STAR) begin
          w.st.phase   = mdls_pkg::PH_BOLD;
          w.st.prev_bs = 1'b0;
          return w;
        end
        if (italic_ok(w.st)) begin
          w.st.phase      = mdls_pkg::PH_SPAN;
          w.st.span_delim = mdls_pkg::CH_STAR;
        end else begin
          w          = put_char(w, mdls_pkg::CH_STAR);
          w.st.phase = mdls_pkg::PH_TOP;
        end
        w.st.prev_bs = 1'b0;
        w = body_simple(w, c);
      end
      mdls_pkg::PH_BOLD_STAR: begin
        if (c == mdls_pkg::CH_STAR) begin
          w.st.phase   = mdls_pkg::PH_TOP;
          w.st.prev_bs = 1'b0;
          return w;
        end
        w            = put_char(w, mdls_pkg::CH_STAR);
        w.st.phase   = mdls_pkg::PH_BOLD;
        w.st.prev_bs = 1'b0;
        w = body_simple(w, c);
      end
      mdls_pkg::PH_LINK_AFTER: begin
        if (c == mdls_pkg::CH_LPAREN) begin
          w.st.phase   = mdls_pkg::PH_URL;
          w.st.prev_bs = 1'b0;
          return w;
        end
        w.st.phase = mdls_pkg::PH_TOP;
        w = body_simple(w, c);
      end
      default: begin
        w = body_simple(w, c);
      end
    endcase
    return w;
  endfunction

  function automatic mdls_pkg::work_t feed_byte(mdls_pkg::work_t w, logic [7:0] c);
    logic [9:0] ind_sum;
    logic       is_blank;
    ind_sum  = {1'b0, w.st.indent} + ((c == mdls_pkg::CH_TAB) ? 10'd2 : 10'd1);
    is_blank = (c == mdls_pkg::CH_SPACE) || (c == mdls_pkg::CH_TAB);
    case (w.st.phase)
      mdls_pkg::PH_INDENT: begin
        if (is_blank) begin
          w.st.indent = (ind_sum > mdls_pkg::INDENT_MAX) ?
                        mdls_pkg::INDENT_MAX[8:0] : ind_sum[8:0];
        end else if (c == mdls_pkg::CH_HASH) begin
          w.st.hash_total = 3'd1;
          w.st.phase      = mdls_pkg::PH_HASH;
        end else if (c == mdls_pkg::CH_DASH || c == mdls_pkg::CH_STAR) begin
          w.st.pend_star = (c == mdls_pkg::CH_STAR);
          w.st.phase     = mdls_pkg::PH_MARKER;
          return w;
        end else if (c == mdls_pkg::CH_GT) begin
          w.st.line_type = mdls_pkg::LT_QUOTE;
          w.st.phase     = mdls_pkg::PH_QUOTE_SPACE;
        end else if (c == mdls_pkg::CH_TICK) begin
          w.st.line_type = mdls_pkg::LT_CODE;
          w.st.phase     = mdls_pkg::PH_TOP;
        end else begin
          w.st.phase = mdls_pkg::PH_TOP;
          return body_simple(w, c);
        end
        w.st.prev_bs = 1'b0;
      end
      mdls_pkg::PH_HASH: begin
        if (c == mdls_pkg::CH_HASH) begin
          if (w.st.hash_total != 3'd7) begin
            w.st.hash_total = w.st.hash_total + 3'd1;
          end
          w.st.prev_bs = 1'b0;
          return w;
        end
        w.st.line_type = heading_type(w.st.hash_total);
        w.st.phase     = mdls_pkg::PH_TOP;
        if (c == mdls_pkg::CH_SPACE) begin
          w.st.prev_bs = 1'b0;
        end else begin
          w = body_simple(w, c);
        end
      end
      mdls_pkg::PH_MARKER: begin
        if (is_blank) begin
          w.st.line_type = mdls_pkg::LT_LIST;
          w.st.phase     = mdls_pkg::PH_LIST_SKIP;
          w.st.prev_bs   = 1'b0;
          return w;
        end
        // Replay the held marker byte as body text, then this byte
        w.st.phase = mdls_pkg::PH_TOP;
        w = body_simple(w, w.st.pend_star ? mdls_pkg::CH_STAR : mdls_pkg::CH_DASH);
        w = body_byte(w, c);
      end
      mdls_pkg::PH_QUOTE_SPACE: begin
        w.st.phase = mdls_pkg::PH_TOP;
        if (c == mdls_pkg::CH_SPACE) begin
          w.st.prev_bs = 1'b0;
        end else begin
          w = body_simple(w, c);
        end
      end
      mdls_pkg::PH_LIST_SKIP: begin
        if (is_blank) begin
          w.st.prev_bs = 1'b0;
          return w;
        end
        w.st.phase = mdls_pkg::PH_TOP;
        w = body_simple(w, c);
      end
      default: begin
        w = body_byte(w, c);
      end
    endcase
    return w;
  endfunction

  function automatic mdls_pkg::work_t close_line(mdls_pkg::work_t w);
    mdls_pkg::res_t r;
    case (w.st.phase)
      mdls_pkg::PH_HASH: begin
        w.st.line_type = heading_type(w.st.hash_total);
      end
      mdls_pkg::PH_MARKER: begin
        w = put_char(w, w.st.pend_star ? mdls_pkg::CH_STAR : mdls_pkg::CH_DASH);
      end
      mdls_pkg::PH_BOLD_STAR: begin
        w = put_char(w, mdls_pkg::CH_STAR);
      end
      mdls_pkg::PH_STAR: begin
        if (!italic_ok(w.st)) begin
          w = put_char(w, mdls_pkg::CH_STAR);
        end
      end
      default: begin
      end
    endcase
    r.text_char  = mdls_pkg::CH_NUL;
    r.line_type  = w.st.line_type;
    r.indent     = w.st.indent;
    r.char_count = w.st.kept;
    r.line_done  = 1'b1;
    return append(w, r);
  endfunction

  mdls_pkg::work_t init_w;

  always_comb begin
    init_w    = '0;
    init_w.st = line_i;
    work_o    = close_i ? close_line(init_w) : feed_byte(init_w, ch_i);
  end

endmodule

[rtl/core/markdown_line_markup_stripper_top.sv]
// Markdown line markup stripper.
// Input channel (in_valid_i / in_stall_o): one raw byte per item in ch_i, or
// an end-of-file item with end_of_file_i high. Byte 10 closes a line.
// Output channel (out_valid_o / out_stall_i): kept characters of the line,
// each with the line's type, indent and running kept count, followed by one
// summary item per line with line_done_o high.
// The first result of an item passes through the input register and is then
// written to the result queue, from whose head the output is read.
// Throughput: one input item per cycle while the receiver takes results.
// An item yields at most two results; the four-entry result queue drains one
// per cycle, so items that yield two results are paced by the output port.
// The input register takes a new item whenever the queue has room for two
// results, including while a finished result still waits at the output.
// Reset clears the parse state, the input register and the result queue.
// When the receiver stalls, the head result holds; once the queue cannot
// take two more results, in_stall_o rises and the held byte waits.
module markdown_line_markup_stripper_top #(
  parameter int unsigned LINE_LIMIT = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  input  logic       end_of_file_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] text_char_o,
  output logic [2:0] line_type_o,
  output logic [8:0] indent_o,
  output logic [7:0] char_count_o,
  output logic       line_done_o
);

  localparam int unsigned RAW_W = $clog2(LINE_LIMIT + 1);
  localparam logic [RAW_W-1:0] RAW_LIMIT = RAW_W'(LINE_LIMIT);

  logic                           in_valid_q, in_valid_d;
  logic [7:0]                     ch_q;
  logic                           eof_q;
  mdls_pkg::line_t                line_q, line_d;
  logic [RAW_W-1:0]               raw_q, raw_d;
  logic                           zero_q, zero_d;
  mdls_pkg::res_t                 fifo_q [mdls_pkg::FIFO_DEPTH];
  logic [mdls_pkg::PTR_W-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [mdls_pkg::CNT_W-1:0]     cnt_q, cnt_d;

  logic            accept_in, step, pop;
  logic            room_line, is_nl, close_req, feed_req, clear_line;
  logic [1:0]      push_n;
  mdls_pkg::work_t work;

  // Room for two results keeps a worst-case item from overrunning the queue
  assign step       = in_valid_q &&
                      (cnt_q <= mdls_pkg::CNT_W'(mdls_pkg::FIFO_DEPTH - 2));
  assign in_stall_o = in_valid_q && !step;
  assign accept_in  = in_valid_i && !in_stall_o;

  assign is_nl      = (ch_q == mdls_pkg::CH_NL);
  assign room_line  = (raw_q < RAW_LIMIT);
  assign close_req  = eof_q ? (raw_q != '0) : is_nl;
  assign clear_line = eof_q || is_nl;
  assign feed_req   = !eof_q && !is_nl && room_line && !zero_q &&
                      (ch_q != mdls_pkg::CH_NUL);

  mdls_parse u_parse (
    .line_i  (line_q),
    .ch_i    (ch_q),
    .close_i (close_req),
    .work_o  (work)
  );

  assign push_n = (step && (close_req || feed_req)) ? work.n : 2'd0;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept_in) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end

    line_d = line_q;
    raw_d  = raw_q;
    zero_d = zero_q;
    if (step) begin
      if (clear_line) begin
        line_d = mdls_pkg::LINE_RESET;
        raw_d  = '0;
        zero_d = 1'b0;
      end else if (room_line) begin
        raw_d = raw_q + RAW_W'(1);
        if (ch_q == mdls_pkg::CH_NUL) begin
          zero_d = 1'b1;
        end
        if (feed_req) begin
          line_d = work.st;
        end
      end
    end
  end

  assign pop  = out_valid_o && !out_stall_i;
  assign wr_d = wr_q + mdls_pkg::PTR_W'(push_n);
  assign rd_d = rd_q + mdls_pkg::PTR_W'(pop);
  assign cnt_d = cnt_q + mdls_pkg::CNT_W'(push_n) - mdls_pkg::CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      line_q     <= mdls_pkg::LINE_RESET;
      raw_q      <= '0;
      zero_q     <= 1'b0;
      wr_q       <= '0;
      rd_q       <= '0;
      cnt_q      <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      line_q     <= line_d;
      raw_q      <= raw_d;
      zero_q     <= zero_d;
      wr_q       <= wr_d;
      rd_q       <= rd_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      ch_q  <= ch_i;
      eof_q <= end_of_file_i;
    end
    if (push_n != 2'd0) begin
      fifo_q[wr_q] <= work.r0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_q + mdls_pkg::PTR_W'(1)] <= work.r1;
    end
  end

  assign out_valid_o  = (cnt_q != '0);
  assign text_char_o  = fifo_q[rd_q].text_char;
  assign line_type_o  = fifo_q[rd_q].line_type;
  assign indent_o     = fifo_q[rd_q].indent;
  assign char_count_o = fifo_q[rd_q].char_count;
  assign line_done_o  = fifo_q[rd_q].line_done;

  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mdls_pkg::CNT_W'(mdls_pkg::FIFO_DEPTH))
    else $error("result queue overrun");

  a_line_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && clear_line) |=> (line_q.phase == mdls_pkg::PH_INDENT &&
                              line_q.kept == 8'd0 && raw_q == '0))
    else $error("line state not cleared at line end");

  a_raw_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    raw_q <= RAW_LIMIT)
    else $error("raw length past line limit");

  a_text_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !line_done_o) |-> (char_count_o != 8'd0))
    else $error("kept character with zero count");

endmodule
